// File: rtl/core/bfm_pkg.sv
// shared types, constants and width helpers for the buffer frame manager
package bfm_pkg;

   localparam int BFM_FRAMES = 8;
   localparam int BFM_CFG_W = 4;
   localparam int BFM_BLK_W = 8;
   localparam int BFM_FIDX_W = 3;
   localparam logic [BFM_CFG_W-1:0] BFM_CFG_RESET = 4'd8;

   typedef enum logic [1:0] {
      CMD_GET,
      CMD_PIN,
      CMD_UNPIN,
      CMD_RSVD
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT,
      ST_LOADED,
      ST_FULL,
      ST_NOT_RESIDENT,
      ST_BAD
   } status_type;

   typedef enum logic {
      BFM_IDLE,
      BFM_EXEC
   } state_type;

   typedef struct packed {
      logic load_req;
      logic commit;
      logic ptr_reduce;
   } ctl_cmd_type;

   typedef struct packed {
      logic ptr_ok;
   } dp_status_type;

   // bits to index a frame
   function automatic int bfm_idx_w(int frames);
      return (frames > 1) ? $clog2(frames) : 1;
   endfunction

   // bits to hold a frame count
   function automatic int bfm_cnt_w(int frames);
      return $clog2(frames + 1);
   endfunction

   // frame index on the result port: three bits unless the pool needs more
   function automatic int bfm_fidx_w(int frames);
      return (frames > 8) ? $clog2(frames) : BFM_FIDX_W;
   endfunction

endpackage

// File: rtl/core/bfm_ifs.sv
// request, response and configuration channel interfaces
interface bfm_req_if import bfm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic [BFM_BLK_W-1:0] block_number;
   logic                 mark_dirty;

   modport source (output valid, output cmd, output block_number, output mark_dirty,
                   input ready);
   modport sink (input valid, input cmd, input block_number, input mark_dirty,
                 output ready);
endinterface

interface bfm_rsp_if import bfm_pkg::*; #(
   parameter int FIDX_W = BFM_FIDX_W
) ();
   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [FIDX_W-1:0]    frame_index;
   logic                 read_request;
   logic                 writeback_valid;
   logic [BFM_BLK_W-1:0] writeback_block;

   modport source (output valid, output status, output frame_index, output read_request,
                   output writeback_valid, output writeback_block, input ready);
   modport sink (input valid, input status, input frame_index, input read_request,
                 input writeback_valid, input writeback_block, output ready);
endinterface

interface bfm_csr_if import bfm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BFM_CFG_W-1:0] frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink (input valid, input frames_in_use, output ready);
endinterface

// File: rtl/core/bfm_ctrl.sv
// controller: request/execute sequencing and result register handshake
module bfm_ctrl import bfm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output ctl_cmd_type   ctl_cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BFM_IDLE: begin
            if (req_valid) state_in = BFM_EXEC;
         end
         BFM_EXEC: begin
            if (dp_status.ptr_ok && out_free) state_in = BFM_IDLE;
         end
         default: state_in = BFM_IDLE;
      endcase
   end

   always_comb begin
      req_ready          = 1'b0;
      ctl_cmd.load_req   = 1'b0;
      ctl_cmd.commit     = 1'b0;
      ctl_cmd.ptr_reduce = 1'b0;
      case (state_ff)
         BFM_IDLE: begin
            req_ready        = 1'b1;
            ctl_cmd.load_req = req_valid;
         end
         BFM_EXEC: begin
            // pointer is brought below the frame count before any search
            ctl_cmd.ptr_reduce = !dp_status.ptr_ok;
            ctl_cmd.commit     = dp_status.ptr_ok && out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign out_valid_in = ctl_cmd.commit || (out_valid_ff && !rsp_ready);
   assign rsp_valid    = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BFM_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: rtl/core/bfm_datapath.sv
// datapath: frame table, tag compare, empty and victim pick, result register
module bfm_datapath import bfm_pkg::*; #(
   parameter int FRAMES = BFM_FRAMES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_cmd,
   input  logic [BFM_BLK_W-1:0]      req_block_number,
   input  logic                      req_mark_dirty,
   input  logic                      csr_write,
   input  logic [BFM_CFG_W-1:0]      csr_frames_in_use,
   input  ctl_cmd_type               ctl_cmd,
   output dp_status_type             dp_status,
   output logic [2:0]                rsp_status,
   output logic [bfm_fidx_w(FRAMES)-1:0] rsp_frame_index,
   output logic                      rsp_read_request,
   output logic                      rsp_writeback_valid,
   output logic [BFM_BLK_W-1:0]      rsp_writeback_block
);

   localparam int IDX_W  = bfm_idx_w(FRAMES);
   localparam int CNT_W  = bfm_cnt_w(FRAMES);
   localparam int FIDX_W = bfm_fidx_w(FRAMES);

   // request register
   logic [1:0]           cmd_ff;
   logic [BFM_BLK_W-1:0] blk_ff;
   logic                 mark_ff;

   // frame table
   logic [BFM_BLK_W-1:0] frame_tag_ff [FRAMES];
   logic [FRAMES-1:0]    frame_valid_ff, frame_valid_in;
   logic [FRAMES-1:0]    frame_dirty_ff, frame_dirty_in;
   logic [FRAMES-1:0]    frame_pinned_ff, frame_pinned_in;
   logic [IDX_W-1:0]     victim_ptr_ff, victim_ptr_in;
   logic [IDX_W-1:0]     start_ff, start_in;
   logic [BFM_CFG_W-1:0] frames_in_use_ff;

   // result register
   logic [2:0]           status_ff;
   logic [FIDX_W-1:0]    fidx_ff;
   logic                 rd_ff;
   logic                 wbv_ff;
   logic [BFM_BLK_W-1:0] wbb_ff;

   logic [CNT_W-1:0]     n_act;
   logic [FRAMES-1:0]    hit_vec, empty_vec, cand_vec, cand_hi_vec;
   logic [IDX_W-1:0]     hit_idx, empty_idx, cand_idx, cand_hi_idx, victim_idx;
   logic [CNT_W-1:0]     victim_next;
   cmd_type              cmd_e;
   status_type           status_c;
   logic [IDX_W-1:0]     tgt;
   logic                 bad, load, evict, set_pin, clr_pin, set_dirty, wbv_c;
   logic [BFM_BLK_W-1:0] wbb_c;

   // frames_in_use of zero acts as one, above the pool acts as the pool
   always_comb begin
      if (frames_in_use_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (32'(frames_in_use_ff) > FRAMES) begin
         n_act = CNT_W'(FRAMES);
      end else begin
         n_act = CNT_W'(frames_in_use_ff);
      end
   end

   // search start is a copy of the pointer reduced below the frame count
   assign dp_status.ptr_ok = CNT_W'(start_ff) < n_act;

   always_comb begin
      start_in = start_ff;
      if (ctl_cmd.load_req) begin
         start_in = victim_ptr_ff;
      end else if (ctl_cmd.ptr_reduce) begin
         start_in = IDX_W'(CNT_W'(start_ff) - n_act);
      end
   end

   // parallel compare over the active frames
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         hit_vec[i]     = (CNT_W'(i) < n_act) && frame_valid_ff[i]
                          && (frame_tag_ff[i] == blk_ff);
         empty_vec[i]   = (CNT_W'(i) < n_act) && !frame_valid_ff[i];
         cand_vec[i]    = (CNT_W'(i) < n_act) && !frame_pinned_ff[i];
         cand_hi_vec[i] = cand_vec[i] && (IDX_W'(i) >= start_ff);
      end
   end

   // lowest set bit of each vector
   always_comb begin
      hit_idx     = '0;
      empty_idx   = '0;
      cand_idx    = '0;
      cand_hi_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (hit_vec[i])     hit_idx     = IDX_W'(i);
         if (empty_vec[i])   empty_idx   = IDX_W'(i);
         if (cand_vec[i])    cand_idx    = IDX_W'(i);
         if (cand_hi_vec[i]) cand_hi_idx = IDX_W'(i);
      end
   end

   // round robin: first unpinned at or after the pointer, else wrap to the lowest
   assign victim_idx  = (|cand_hi_vec) ? cand_hi_idx : cand_idx;
   assign victim_next = CNT_W'(victim_idx) + CNT_W'(1);

   always_comb begin
      cmd_e     = cmd_type'(cmd_ff);
      bad       = (cmd_e == CMD_RSVD) || (blk_ff == '0);
      status_c  = ST_HIT;
      tgt       = '0;
      load      = 1'b0;
      evict     = 1'b0;
      set_pin   = 1'b0;
      clr_pin   = 1'b0;
      set_dirty = 1'b0;
      wbv_c     = 1'b0;
      wbb_c     = '0;
      if (bad) begin
         status_c = ST_BAD;
      end else if (cmd_e == CMD_UNPIN) begin
         if (|hit_vec) begin
            tgt     = hit_idx;
            clr_pin = 1'b1;
         end else begin
            status_c = ST_NOT_RESIDENT;
         end
      end else begin
         if (|hit_vec) begin
            tgt = hit_idx;
         end else if (|empty_vec) begin
            tgt      = empty_idx;
            load     = 1'b1;
            status_c = ST_LOADED;
         end else if (|cand_vec) begin
            tgt      = victim_idx;
            load     = 1'b1;
            evict    = 1'b1;
            status_c = ST_LOADED;
            wbv_c    = frame_dirty_ff[victim_idx];
            wbb_c    = frame_dirty_ff[victim_idx] ? frame_tag_ff[victim_idx] : '0;
         end else begin
            status_c = ST_FULL;
         end
         if (status_c != ST_FULL) begin
            set_pin   = (cmd_e == CMD_PIN);
            set_dirty = (cmd_e == CMD_GET) && mark_ff;
         end
      end
   end

   always_comb begin
      frame_valid_in  = frame_valid_ff;
      frame_dirty_in  = frame_dirty_ff;
      frame_pinned_in = frame_pinned_ff;
      victim_ptr_in   = victim_ptr_ff;
      if (ctl_cmd.commit) begin
         if (load) begin
            // a fresh load starts clean and unpinned before the command's marks
            frame_valid_in[tgt]  = 1'b1;
            frame_dirty_in[tgt]  = set_dirty;
            frame_pinned_in[tgt] = set_pin;
         end else begin
            if (set_pin)   frame_pinned_in[tgt] = 1'b1;
            if (clr_pin)   frame_pinned_in[tgt] = 1'b0;
            if (set_dirty) frame_dirty_in[tgt]  = 1'b1;
         end
         if (evict) begin
            victim_ptr_in = (victim_next == n_act) ? '0 : IDX_W'(victim_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff   <= '0;
         frame_dirty_ff   <= '0;
         frame_pinned_ff  <= '0;
         victim_ptr_ff    <= '0;
         start_ff         <= '0;
         frames_in_use_ff <= BFM_CFG_RESET;
      end else begin
         frame_valid_ff  <= frame_valid_in;
         frame_dirty_ff  <= frame_dirty_in;
         frame_pinned_ff <= frame_pinned_in;
         victim_ptr_ff   <= victim_ptr_in;
         start_ff        <= start_in;
         if (csr_write) frames_in_use_ff <= csr_frames_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load_req) begin
         cmd_ff  <= req_cmd;
         blk_ff  <= req_block_number;
         mark_ff <= req_mark_dirty;
      end
      if (ctl_cmd.commit && load) begin
         frame_tag_ff[tgt] <= blk_ff;
      end
      if (ctl_cmd.commit) begin
         status_ff <= status_c;
         fidx_ff   <= (status_c == ST_HIT || status_c == ST_LOADED) ? FIDX_W'(tgt) : '0;
         rd_ff     <= load;
         wbv_ff    <= wbv_c;
         wbb_ff    <= wbb_c;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_frame_index     = fidx_ff;
   assign rsp_read_request    = rd_ff;
   assign rsp_writeback_valid = wbv_ff;
   assign rsp_writeback_block = wbb_ff;

endmodule

// File: rtl/core/buffer_frame_manager.sv
// Buffer frame manager: tracks which disk block sits in each of FRAMES frames, with valid,
// dirty and pinned marks, and answers get, pin and unpin requests with one result item each.
// A request is registered and then executed: in the execute state the datapath
// compares every active frame's tag in parallel, picks the lowest empty frame or the
// round-robin victim, updates the frame table and loads the result register. A new item is
// taken in the cycle after a result is loaded, even while that result waits on rsp ready;
// the execute state holds while the previous result has not been taken yet, and while the
// copy of the victim pointer is being reduced. The victim search starts at the victim
// pointer modulo the frame count; the stored pointer changes only on an eviction. While the
// pointer is at or beyond the active frame count, each item first subtracts the frame count
// from a copy of the pointer, repeatedly, until the copy lies below it. The configuration
// write is always ready and must only be issued while the block is idle.
module buffer_frame_manager import bfm_pkg::*; #(
   parameter int FRAMES = BFM_FRAMES
) (
   input logic        clock,
   input logic        reset,
   bfm_req_if.sink    req_chan,
   bfm_rsp_if.source  rsp_chan,
   bfm_csr_if.sink    csr_chan
);

   localparam int FIDX_W = bfm_fidx_w(FRAMES);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   assign csr_chan.ready = 1'b1;

   bfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   bfm_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_chan.cmd),
      .req_block_number    (req_chan.block_number),
      .req_mark_dirty      (req_chan.mark_dirty),
      .csr_write           (csr_chan.valid),
      .csr_frames_in_use   (csr_chan.frames_in_use),
      .ctl_cmd             (ctl_cmd),
      .dp_status           (dp_status),
      .rsp_status          (rsp_chan.status),
      .rsp_frame_index     (rsp_chan.frame_index[FIDX_W-1:0]),
      .rsp_read_request    (rsp_chan.read_request),
      .rsp_writeback_valid (rsp_chan.writeback_valid),
      .rsp_writeback_block (rsp_chan.writeback_block)
   );

endmodule

// File: rtl/core/bfm_checker.sv
// port-level checks for the buffer frame manager, bound to the top level
module bfm_checker import bfm_pkg::*; #(
   parameter int FIDX_W = BFM_FIDX_W
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [2:0]           rsp_status,
   input logic [FIDX_W-1:0]    rsp_frame_index,
   input logic                 rsp_read_request,
   input logic                 rsp_writeback_valid,
   input logic [BFM_BLK_W-1:0] rsp_writeback_block
);

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_index) && $stable(rsp_writeback_block))
      else $error("result changed while stalled");

   // one item in flight: no new item right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one executes");

   // a disk read is requested exactly for a load
   a_read_on_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_read_request == (rsp_status == ST_LOADED)))
      else $error("read request does not match load status");

   // writeback only on a load, and never reports block zero
   a_wb_on_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writeback_valid |-> rsp_status == ST_LOADED
         && rsp_writeback_block != '0)
      else $error("writeback without a load");

   // failed requests carry no frame or writeback
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_RESIDENT
         || rsp_status == ST_BAD)
      |-> rsp_frame_index == '0 && !rsp_writeback_valid && rsp_writeback_block == '0)
      else $error("failed request reports a frame or writeback");

endmodule

bind buffer_frame_manager bfm_checker #(
   .FIDX_W (FIDX_W)
) u_bfm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_frame_index     (rsp_chan.frame_index[FIDX_W-1:0]),
   .rsp_read_request    (rsp_chan.read_request),
   .rsp_writeback_valid (rsp_chan.writeback_valid),
   .rsp_writeback_block (rsp_chan.writeback_block)
);

// File: test/bfm_frame_monitor.sv
// monitor for the buffer frame manager: tracks the frame table, predicts each response and compares
module bfm_frame_monitor import bfm_pkg::*; (
   input  logic clock,
   input  logic reset,
   bfm_req_if   req_chan,
   bfm_rsp_if   rsp_chan,
   bfm_csr_if   csr_chan,
   output int   error_count,
   output int   pending_count
);

   typedef struct packed {
      status_type           status;
      logic [2:0]           frame_index;
      logic                 read_request;
      logic                 writeback_valid;
      logic [BFM_BLK_W-1:0] writeback_block;
   } frame_reply_type;

   logic [BFM_BLK_W-1:0]  tag_table [BFM_FRAMES];
   logic [BFM_FRAMES-1:0] resident;
   logic [BFM_FRAMES-1:0] modified;
   logic [BFM_FRAMES-1:0] pinned;
   int unsigned           victim_ptr;
   logic [BFM_CFG_W-1:0]  pool_size;
   frame_reply_type       owed_replies[$];
   int                    errors = 0;

   // applies one request to the tracked frame table and returns the response it earns
   function automatic frame_reply_type serve_request(cmd_type cmd, logic [BFM_BLK_W-1:0] blk,
                                                     logic dirty);
      frame_reply_type r;
      int n, slot, start, idx, i;
      r = '0;
      r.status = ST_HIT;
      n = (pool_size == 0) ? 1 : (pool_size > BFM_FRAMES) ? BFM_FRAMES : int'(pool_size);
      if (cmd == CMD_RSVD || blk == 0) begin
         r.status = ST_BAD;
         return r;
      end
      // lowest matching frame wins when tags are duplicated
      slot = -1;
      for (i = n - 1; i >= 0; i--)
         if (resident[i] && tag_table[i] == blk) slot = i;
      if (cmd == CMD_UNPIN) begin
         if (slot < 0) begin
            r.status = ST_NOT_RESIDENT;
         end else begin
            pinned[slot] = 1'b0;
            r.frame_index = slot[2:0];
         end
         return r;
      end
      if (slot < 0) begin
         for (i = n - 1; i >= 0; i--)
            if (!resident[i]) slot = i;
         if (slot < 0) begin
            // round robin from the pointer, first unpinned frame in search order
            start = int'(victim_ptr % n);
            for (i = n - 1; i >= 0; i--) begin
               idx = (start + i) % n;
               if (!pinned[idx]) slot = idx;
            end
            if (slot < 0) begin
               r.status = ST_FULL;
               return r;
            end
            if (modified[slot]) begin
               r.writeback_valid = 1'b1;
               r.writeback_block = tag_table[slot];
            end
            victim_ptr = (slot + 1) % n;
         end
         tag_table[slot] = blk;
         resident[slot] = 1'b1;
         modified[slot] = 1'b0;
         pinned[slot] = 1'b0;
         r.status = ST_LOADED;
         r.read_request = 1'b1;
      end
      r.frame_index = slot[2:0];
      if (cmd == CMD_PIN) pinned[slot] = 1'b1;
      else if (dirty) modified[slot] = 1'b1;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      frame_reply_type want;
      if (reset) begin
         resident = '0;
         modified = '0;
         pinned = '0;
         victim_ptr = 0;
         pool_size = BFM_CFG_RESET;
         owed_replies.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) pool_size = csr_chan.frames_in_use;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_replies.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: expected none, got status %0d frame %0d",
                        $time, rsp_chan.status, rsp_chan.frame_index);
            end else begin
               want = owed_replies.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_chan.status));
               check_field("frame_index", 8'(want.frame_index), 8'(rsp_chan.frame_index));
               check_field("read_request", 8'(want.read_request), 8'(rsp_chan.read_request));
               check_field("writeback_valid", 8'(want.writeback_valid),
                           8'(rsp_chan.writeback_valid));
               check_field("writeback_block", want.writeback_block, rsp_chan.writeback_block);
            end
         end
         if (req_chan.valid && req_chan.ready)
            owed_replies.push_back(serve_request(cmd_type'(req_chan.cmd), req_chan.block_number,
                                                 req_chan.mark_dirty));
      end
      pending_count <= owed_replies.size();
      error_count <= errors;
   end

endmodule

// File: test/tb.sv
// top level: drives requests, pool size writes and response stalls, then reports the verdict
module tb;
   import bfm_pkg::*;

   localparam int IDLE_LIMIT = 600;
   localparam int PHASE_ITEMS = 140;
   localparam int PHASES = 12;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   idle_cycles = 0;
   int   sent = 0;
   int   size_writes = 0;
   bit   steady_src = 0;
   bit   steady_snk = 0;
   int   pool_plan [PHASES] = '{8, 1, 0, 15, 3, 2, 9, 5, 4, 7, 6, 12};

   bfm_req_if req_chan ();
   bfm_rsp_if rsp_chan ();
   bfm_csr_if csr_chan ();

   buffer_frame_manager uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   bfm_frame_monitor frame_mon (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .error_count   (errors),
      .pending_count (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_request(cmd_type cmd, logic [BFM_BLK_W-1:0] blk, logic dirty);
      int gap;
      gap = steady_src ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.block_number <= blk;
      req_chan.mark_dirty <= dirty;
      @(posedge clock iff (req_chan.valid && req_chan.ready));
      @(negedge clock);
      sent++;
   endtask

   // pool size may only change with nothing in flight
   task automatic set_pool_size(logic [BFM_CFG_W-1:0] size);
      req_chan.valid <= 1'b0;
      @(negedge clock iff pending == 0);
      repeat (12) @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.frames_in_use <= size;
      @(posedge clock iff (csr_chan.valid && csr_chan.ready));
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      size_writes++;
   endtask

   task automatic random_request(int active);
      int pick;
      cmd_type cmd;
      logic [BFM_BLK_W-1:0] blk;
      pick = $urandom_range(0, 99);
      cmd = (pick < 50) ? CMD_GET : (pick < 70) ? CMD_PIN : (pick < 95) ? CMD_UNPIN : CMD_RSVD;
      // mostly a small working set so hits, evictions and pin pressure happen
      pick = $urandom_range(0, 99);
      if (pick < 4) blk = '0;
      else if (pick < 14) blk = BFM_BLK_W'($urandom_range(1, 255));
      else blk = BFM_BLK_W'($urandom_range(1, active * 2 + 2));
      send_request(cmd, blk, 1'($urandom_range(0, 1)));
   endtask

   // response side: random stall before each item, with stall-free stretches
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if ($urandom_range(0, 39) == 0) steady_snk = !steady_snk;
         stall = steady_snk ? 0 : $urandom_range(0, 17);
         repeat (stall) begin
            rsp_chan.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock iff (rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int active;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_GET;
      req_chan.block_number = '0;
      req_chan.mark_dirty = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.frames_in_use = BFM_CFG_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: hits, misses, bad block and command, unpin miss, eviction with writeback
      send_request(CMD_GET, 8'd255, 1'b1);
      send_request(CMD_GET, 8'd255, 1'b0);
      send_request(CMD_GET, 8'd0, 1'b1);
      send_request(CMD_RSVD, 8'd5, 1'b0);
      send_request(CMD_UNPIN, 8'd77, 1'b0);
      send_request(CMD_PIN, 8'd1, 1'b1);
      send_request(CMD_UNPIN, 8'd1, 1'b0);
      send_request(CMD_GET, 8'd128, 1'b1);
      send_request(CMD_GET, 8'd127, 1'b0);
      set_pool_size(4'd2);
      send_request(CMD_GET, 8'd3, 1'b0);
      send_request(CMD_PIN, 8'd4, 1'b0);
      send_request(CMD_PIN, 8'd3, 1'b1);
      send_request(CMD_GET, 8'd5, 1'b0);
      send_request(CMD_UNPIN, 8'd9, 1'b0);
      send_request(CMD_UNPIN, 8'd3, 1'b0);
      send_request(CMD_UNPIN, 8'd4, 1'b0);
      send_request(CMD_GET, 8'd6, 1'b1);
      // zero acts as a single frame, pointer past the count wraps
      set_pool_size(4'd0);
      send_request(CMD_GET, 8'd7, 1'b0);
      send_request(CMD_PIN, 8'd7, 1'b0);
      send_request(CMD_GET, 8'd8, 1'b0);
      send_request(CMD_UNPIN, 8'd7, 1'b0);
      set_pool_size(4'd15);
      send_request(CMD_GET, 8'd200, 1'b1);
      send_request(CMD_PIN, 8'd128, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         set_pool_size(BFM_CFG_W'(pool_plan[p]));
         active = (pool_plan[p] == 0) ? 1 : (pool_plan[p] > BFM_FRAMES) ? BFM_FRAMES : pool_plan[p];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 39) == 0) steady_src = !steady_src;
            random_request(active);
         end
      end

      req_chan.valid <= 1'b0;
      @(negedge clock iff pending == 0);
      repeat (20) @(negedge clock);
      $display("ran %0d requests over %0d pool size writes, sizes 0 to 15 incl. out of range",
               sent, size_writes);
      $display("gaps and stalls of 0 to 17 cycles on both channels, with stall-free stretches");
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/bfm_pkg.sv
rtl/core/bfm_ifs.sv
rtl/core/bfm_ctrl.sv
rtl/core/bfm_datapath.sv
rtl/core/buffer_frame_manager.sv
rtl/core/bfm_checker.sv
test/bfm_frame_monitor.sv
test/tb.sv
